@@ hdl/gcd_pkg.sv @@
// Shared constants, types and elaboration-time table functions for the
// great-circle distance pipeline. No dependencies.
package gcd_pkg;

    localparam int ANGLE_FRACTION_BITS_DEF = 23;
    localparam int CORDIC_STEPS_DEF        = 32;
    localparam int MAX_STEPS               = 40;

    localparam int LAT_W     = 31;
    localparam int LON_W     = 32;
    localparam int DIST_W    = 31;
    localparam int RADIUS_W  = 29;
    localparam int NUM_LANES = 4;
    // CORDIC x/y words hold Q30 values with headroom for the gain.
    localparam int XY_W      = 34;
    // Angle accumulator of the vectoring CORDIC, Q40.
    localparam int VZ_W      = 44;
    // Haversine term a, Q60 in [0, 1].
    localparam int A_W       = 61;
    // Square root working words.
    localparam int RT_W      = 63;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 29'd417530433;

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q40      = (PI_Q60 + 64'd524288) >> 20;
    localparam logic [63:0] HALF_PI_Q40 = (PI_Q60 + 64'd1048576) >> 21;
    localparam logic [63:0] DEG_RAD_Q36 = (PI_Q60 + (64'd90 << 24)) / (64'd180 << 24);
    localparam logic [A_W-1:0] ONE_Q60  = 61'h1000000000000000;

    typedef logic signed [63:0] atan_tab_t [MAX_STEPS];

    // Restoring long division, used only while constants are worked out.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // One entry of the CORDIC angle table in Q40.
    function automatic logic signed [63:0] atan_entry(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int p;
        sum = '0;
        if (i == 0) begin
            return $signed((PI_Q60 + 64'd2097152) >> 22);
        end
        for (int k = 0; k < 32; k++) begin
            p = i * (2 * k + 1);
            if (p <= 62) begin
                term = $signed(udiv64(64'd1 << (62 - p), 64'(2 * k + 1)));
                if ((k & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return (sum + 64'sd2097152) >>> 22;
    endfunction

    function automatic atan_tab_t atan_table_f();
        atan_tab_t t;
        for (int i = 0; i < MAX_STEPS; i++) begin
            t[i] = atan_entry(i);
        end
        return t;
    endfunction

    localparam atan_tab_t ATAN_TABLE = atan_table_f();

    // Start value of the rotation CORDIC that cancels its gain.
    function automatic logic signed [63:0] gain_start_f(input int steps);
        logic signed [63:0] gx;
        logic signed [63:0] gy;
        logic signed [63:0] gz;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        gx = 64'sh40000000;
        gy = '0;
        gz = '0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            if (i < steps) begin
                dx = gy >>> i;
                dy = gx >>> i;
                if (gz >= 0) begin
                    gx = gx - dx;
                    gy = gy + dy;
                    gz = gz - ATAN_TABLE[i];
                end else begin
                    gx = gx + dx;
                    gy = gy - dy;
                    gz = gz + ATAN_TABLE[i];
                end
            end
        end
        if (gx <= 0) begin
            gx = 64'sd1;
        end
        return $signed(udiv64(64'h1000000000000000 + ($unsigned(gx) >> 1), $unsigned(gx)));
    endfunction

endpackage

@@ hdl/gcd_front.sv @@
// Front end: longitude wrap, latitude difference and conversion of the four
// angles from degrees to Q40 radians. Depends on gcd_pkg.
module gcd_front
    import gcd_pkg::*;
#(
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF,
    parameter int ZW                  = 69 - ANGLE_FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [LAT_W-1:0] lat1,
    input  logic signed [LON_W-1:0] lon1,
    input  logic signed [LAT_W-1:0] lat2,
    input  logic signed [LON_W-1:0] lon2,
    output logic                    out_valid,
    output logic signed [ZW-1:0]    angle [NUM_LANES]
);

    localparam int SHIFT = ANGLE_FRACTION_BITS - 4;
    localparam logic signed [34:0] HALF = 35'(64'd180 << ANGLE_FRACTION_BITS);
    localparam logic signed [34:0] FULL = 35'(64'd360 << ANGLE_FRACTION_BITS);
    localparam logic [30:0] DEG31 = 31'(DEG_RAD_Q36);

    logic [4:0] v_reg;

    logic signed [31:0] lat1_reg, lat2_reg, dlat_reg;
    logic signed [34:0] raw_reg;
    logic signed [34:0] wrap_next;
    logic signed [31:0] ang_reg [NUM_LANES];
    logic [31:0]        mag_next [NUM_LANES];
    logic [31:0]        mag_reg [NUM_LANES];
    logic               neg_reg [NUM_LANES];
    logic               neg2_reg [NUM_LANES];
    logic [62:0]        prod_reg [NUM_LANES];
    logic signed [ZW-1:0] angle_next [NUM_LANES];
    logic signed [ZW-1:0] angle_reg [NUM_LANES];

    // Valid bits follow the data down the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // Exact modulo of 360 degrees: one correction is enough for any input.
    always_comb begin
        if (raw_reg < 0) begin
            wrap_next = raw_reg + FULL;
        end else if (raw_reg >= FULL) begin
            wrap_next = raw_reg - FULL;
        end else begin
            wrap_next = raw_reg;
        end
    end

    // Magnitudes, then rounding of the scaled products; the two differences
    // are half angles and take one more bit of shift.
    always_comb begin
        logic [63:0] rnd;
        logic [63:0] r;
        for (int l = 0; l < NUM_LANES; l++) begin
            mag_next[l] = ang_reg[l][31] ? (~$unsigned(ang_reg[l]) + 32'd1)
                                         : $unsigned(ang_reg[l]);
        end
        for (int l = 0; l < NUM_LANES; l++) begin
            if (l >= 2) begin
                rnd = {1'b0, prod_reg[l]} + (64'd1 << SHIFT);
                r   = rnd >> (SHIFT + 1);
            end else begin
                rnd = {1'b0, prod_reg[l]} + (64'd1 << (SHIFT - 1));
                r   = rnd >> SHIFT;
            end
            angle_next[l] = neg2_reg[l] ? -$signed(ZW'(r)) : $signed(ZW'(r));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat1_reg <= 32'(lat1);
            lat2_reg <= 32'(lat2);
            dlat_reg <= 32'(lat2) - 32'(lat1);
            raw_reg  <= 35'(lon2) - 35'(lon1) + HALF;

            ang_reg[0] <= lat1_reg;
            ang_reg[1] <= lat2_reg;
            ang_reg[2] <= dlat_reg;
            ang_reg[3] <= 32'(wrap_next - HALF);

            for (int l = 0; l < NUM_LANES; l++) begin
                mag_reg[l]   <= mag_next[l];
                neg_reg[l]   <= ang_reg[l][31];
                prod_reg[l]  <= {31'd0, mag_reg[l]} * {32'd0, DEG31};
                neg2_reg[l]  <= neg_reg[l];
                angle_reg[l] <= angle_next[l];
            end
        end
    end

    assign out_valid = v_reg[4];
    assign angle     = angle_reg;

endmodule

@@ hdl/gcd_sincos.sv @@
// Rotation CORDIC, one stage per step, four lanes side by side. Gives the
// cosines of both latitudes and the sines of both half differences.
// Depends on gcd_pkg.
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int ZW           = 69 - ANGLE_FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [ZW-1:0]   angle [NUM_LANES],
    output logic                   out_valid,
    output logic signed [XY_W-1:0] cp1,
    output logic signed [XY_W-1:0] cp2,
    output logic signed [XY_W-1:0] s1,
    output logic signed [XY_W-1:0] s2
);

    localparam int S = CORDIC_STEPS;
    localparam logic signed [63:0]     K64     = gain_start_f(CORDIC_STEPS);
    localparam logic signed [XY_W-1:0] K_START = XY_W'(K64);
    localparam logic signed [ZW-1:0]   PI_Z    = ZW'(PI_Q40);
    localparam logic signed [ZW-1:0]   HPI_Z   = ZW'(HALF_PI_Q40);

    logic [S:0] v_reg;
    logic       ov_reg;

    logic signed [XY_W-1:0] x_next [S+1][NUM_LANES];
    logic signed [XY_W-1:0] y_next [S+1][NUM_LANES];
    logic signed [XY_W-1:0] x_reg  [S+1][NUM_LANES];
    logic signed [XY_W-1:0] y_reg  [S+1][NUM_LANES];
    logic signed [ZW-1:0]   z_next [S][NUM_LANES];
    logic signed [ZW-1:0]   z_reg  [S][NUM_LANES];
    logic                   flip_next [NUM_LANES];
    logic                   flip_reg  [S+1][NUM_LANES];
    logic signed [XY_W-1:0] cp1_reg, cp2_reg, s1_reg, s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[S-1:0], in_valid};
            ov_reg <= v_reg[S];
        end
    end

    always_comb begin
        // Fold angles beyond a quarter turn by pi; results are negated later.
        for (int l = 0; l < NUM_LANES; l++) begin
            x_next[0][l] = K_START;
            y_next[0][l] = '0;
            if (angle[l] > HPI_Z) begin
                z_next[0][l] = angle[l] - PI_Z;
                flip_next[l] = 1'b1;
            end else if (angle[l] < -HPI_Z) begin
                z_next[0][l] = angle[l] + PI_Z;
                flip_next[l] = 1'b1;
            end else begin
                z_next[0][l] = angle[l];
                flip_next[l] = 1'b0;
            end
        end
        // One micro-rotation per stage.
        for (int i = 0; i < S; i++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                if (z_reg[i][l] >= 0) begin
                    x_next[i+1][l] = x_reg[i][l] - (y_reg[i][l] >>> i);
                    y_next[i+1][l] = y_reg[i][l] + (x_reg[i][l] >>> i);
                    if (i < S - 1) begin
                        z_next[i+1][l] = z_reg[i][l] - ZW'(ATAN_TABLE[i]);
                    end
                end else begin
                    x_next[i+1][l] = x_reg[i][l] + (y_reg[i][l] >>> i);
                    y_next[i+1][l] = y_reg[i][l] - (x_reg[i][l] >>> i);
                    if (i < S - 1) begin
                        z_next[i+1][l] = z_reg[i][l] + ZW'(ATAN_TABLE[i]);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= S; k++) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
            end
            for (int k = 0; k < S; k++) begin
                z_reg[k] <= z_next[k];
            end
            flip_reg[0] <= flip_next;
            for (int k = 1; k <= S; k++) begin
                flip_reg[k] <= flip_reg[k-1];
            end
            cp1_reg <= flip_reg[S][0] ? -x_reg[S][0] : x_reg[S][0];
            cp2_reg <= flip_reg[S][1] ? -x_reg[S][1] : x_reg[S][1];
            s1_reg  <= flip_reg[S][2] ? -y_reg[S][2] : y_reg[S][2];
            s2_reg  <= flip_reg[S][3] ? -y_reg[S][3] : y_reg[S][3];
        end
    end

    assign out_valid = ov_reg;
    assign cp1       = cp1_reg;
    assign cp2       = cp2_reg;
    assign s1        = s1_reg;
    assign s2        = s2_reg;

endmodule

@@ hdl/gcd_hav.sv @@
// Haversine term a = s1^2 + round(c1*c2) * round(s2^2) in Q60, clamped to
// [0, 1]. Depends on gcd_pkg.
module gcd_hav
    import gcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] cp1,
    input  logic signed [XY_W-1:0] cp2,
    input  logic signed [XY_W-1:0] s1,
    input  logic signed [XY_W-1:0] s2,
    output logic                   out_valid,
    output logic [A_W-1:0]         a
);

    localparam int PW = 2 * XY_W;
    localparam int MW = 33;
    localparam logic signed [PW-1:0] HALF30 = PW'(64'd536870912);

    logic [3:0] v_reg;

    logic signed [PW-1:0]   pss_reg, pc_reg, ps_reg, pss2_reg, pss3_reg;
    logic signed [MW-1:0]   rc_reg, rs_reg;
    logic signed [2*MW-1:0] pr_reg;
    logic signed [PW-1:0]   sum_next;
    logic [A_W-1:0]         a_next;
    logic [A_W-1:0]         a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // Sum and clamp.
    always_comb begin
        sum_next = pss3_reg + PW'(pr_reg);
        if (sum_next < 0) begin
            a_next = '0;
        end else if (sum_next > $signed(PW'(ONE_Q60))) begin
            a_next = ONE_Q60;
        end else begin
            a_next = A_W'(sum_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pss_reg  <= PW'(s1) * PW'(s1);
            pc_reg   <= PW'(cp1) * PW'(cp2);
            ps_reg   <= PW'(s2) * PW'(s2);
            rc_reg   <= MW'((pc_reg + HALF30) >>> 30);
            rs_reg   <= MW'((ps_reg + HALF30) >>> 30);
            pss2_reg <= pss_reg;
            pr_reg   <= (2*MW)'(rc_reg) * (2*MW)'(rs_reg);
            pss3_reg <= pss2_reg;
            a_reg    <= a_next;
        end
    end

    assign out_valid = v_reg[3];
    assign a         = a_reg;

endmodule

@@ hdl/gcd_sqrt.sv @@
// Two bitwise square roots, one bit per stage, rounded to nearest: sqrt(a)
// and sqrt(1 - a), both Q30. Depends on gcd_pkg.
module gcd_sqrt
    import gcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [A_W-1:0]         a,
    output logic                   out_valid,
    output logic signed [XY_W-1:0] ys,
    output logic signed [XY_W-1:0] xs
);

    localparam int NB = 32;

    logic [NB:0] v_reg;
    logic        ov_reg;

    logic [RT_W-1:0] v_next [NB+1][2];
    logic [RT_W-1:0] r_next [NB+1][2];
    logic [RT_W-1:0] v_reg_a [NB+1][2];
    logic [RT_W-1:0] r_reg_a [NB+1][2];
    logic signed [XY_W-1:0] ys_reg, xs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[NB-1:0], in_valid};
            ov_reg <= v_reg[NB];
        end
    end

    always_comb begin
        logic [RT_W-1:0] b;
        logic [RT_W-1:0] t;
        v_next[0][0] = RT_W'(a);
        v_next[0][1] = RT_W'(ONE_Q60 - a);
        r_next[0][0] = '0;
        r_next[0][1] = '0;
        // Each stage settles one result bit.
        for (int j = 0; j < NB; j++) begin
            b = RT_W'(1) << (62 - 2 * j);
            for (int l = 0; l < 2; l++) begin
                t = r_reg_a[j][l] + b;
                if (v_reg_a[j][l] >= t) begin
                    v_next[j+1][l] = v_reg_a[j][l] - t;
                    r_next[j+1][l] = (r_reg_a[j][l] >> 1) + b;
                end else begin
                    v_next[j+1][l] = v_reg_a[j][l];
                    r_next[j+1][l] = r_reg_a[j][l] >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= NB; k++) begin
                v_reg_a[k] <= v_next[k];
                r_reg_a[k] <= r_next[k];
            end
            // Round to nearest from the remainder.
            ys_reg <= $signed(XY_W'(r_reg_a[NB][0] +
                              RT_W'(v_reg_a[NB][0] > r_reg_a[NB][0])));
            xs_reg <= $signed(XY_W'(r_reg_a[NB][1] +
                              RT_W'(v_reg_a[NB][1] > r_reg_a[NB][1])));
        end
    end

    assign out_valid = ov_reg;
    assign ys        = ys_reg;
    assign xs        = xs_reg;

endmodule

@@ hdl/gcd_vector.sv @@
// Vectoring CORDIC for atan2(ys, xs), one stage per step, then doubling,
// rounding and scaling by the sphere radius. Depends on gcd_pkg.
module gcd_vector
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [XY_W-1:0] ys,
    input  logic signed [XY_W-1:0] xs,
    input  logic [RADIUS_W-1:0]    radius,
    output logic                   out_valid,
    output logic [DIST_W-1:0]      distance
);

    localparam int S     = CORDIC_STEPS;
    localparam int TH_W  = VZ_W - 6;
    localparam int LO_W  = 18;
    localparam int HI_W  = TH_W - LO_W;
    localparam int SUM_W = RADIUS_W + TH_W + 1;

    logic [S+2:0] v_reg;

    logic signed [XY_W-1:0] x_src [S];
    logic signed [XY_W-1:0] y_src [S];
    logic signed [VZ_W-1:0] z_src [S];
    logic signed [XY_W-1:0] x_next [S];
    logic signed [XY_W-1:0] y_next [S];
    logic signed [VZ_W-1:0] z_next [S];
    logic signed [XY_W-1:0] x_reg [S-1];
    logic signed [XY_W-1:0] y_reg [S-1];
    logic signed [VZ_W-1:0] z_reg [S];

    logic [VZ_W:0]             zr_next;
    logic [TH_W-1:0]           theta_reg;
    logic [RADIUS_W+LO_W-1:0]  plo_reg;
    logic [RADIUS_W+HI_W-1:0]  phi_reg;
    logic [SUM_W-1:0]          sum_next;
    logic [DIST_W-1:0]         dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[S+1:0], in_valid};
        end
    end

    always_comb begin
        x_src[0] = xs;
        y_src[0] = ys;
        z_src[0] = '0;
        for (int i = 1; i < S; i++) begin
            x_src[i] = x_reg[i-1];
            y_src[i] = y_reg[i-1];
            z_src[i] = z_reg[i-1];
        end
        // Drive y toward zero one step per stage.
        for (int i = 0; i < S; i++) begin
            if (y_src[i] >= 0) begin
                x_next[i] = x_src[i] + (y_src[i] >>> i);
                y_next[i] = y_src[i] - (x_src[i] >>> i);
                z_next[i] = z_src[i] + VZ_W'(ATAN_TABLE[i]);
            end else begin
                x_next[i] = x_src[i] - (y_src[i] >>> i);
                y_next[i] = y_src[i] + (x_src[i] >>> i);
                z_next[i] = z_src[i] - VZ_W'(ATAN_TABLE[i]);
            end
        end
        // A negative angle counts as zero; 2z in Q32 is z / 2^7 rounded.
        if (z_reg[S-1] < 0) begin
            zr_next = (VZ_W+1)'(64);
        end else begin
            zr_next = {1'b0, $unsigned(z_reg[S-1])} + (VZ_W+1)'(64);
        end
        sum_next = (SUM_W'(phi_reg) << LO_W) + SUM_W'(plo_reg) + (SUM_W'(1) << 31);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < S - 1; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
            end
            z_reg     <= z_next;
            theta_reg <= zr_next[VZ_W:7];
            // Radius times theta in two partial products.
            plo_reg   <= (RADIUS_W+LO_W)'(radius) * (RADIUS_W+LO_W)'(theta_reg[LO_W-1:0]);
            phi_reg   <= (RADIUS_W+HI_W)'(radius) * (RADIUS_W+HI_W)'(theta_reg[TH_W-1:LO_W]);
            dist_reg  <= sum_next[32+DIST_W-1:32];
        end
    end

    assign out_valid = v_reg[S+2];
    assign distance  = dist_reg;

endmodule

@@ hdl/great_circle_distance.sv @@
// Haversine great-circle distance, fully pipelined.
// The front end, the two CORDIC pipelines, the haversine multipliers and the
// 32-stage square root make up the latency from input beat to result beat.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// beat waits on m_ready. Reset clears the valid bits and loads the default
// radius; no clearing pass.
module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [LAT_W-1:0] s_first_latitude,
    input  logic signed [LON_W-1:0] s_first_longitude,
    input  logic signed [LAT_W-1:0] s_second_latitude,
    input  logic signed [LON_W-1:0] s_second_longitude,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DIST_W-1:0]       m_distance,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [RADIUS_W-1:0]     cfg_sphere_radius
);

    localparam int ZW = 69 - ANGLE_FRACTION_BITS;

    logic en;
    logic [RADIUS_W-1:0] radius_reg;

    logic                   f_valid, c_valid, h_valid, q_valid;
    logic signed [ZW-1:0]   angle [NUM_LANES];
    logic signed [XY_W-1:0] cp1, cp2, s1, s2, ys, xs;
    logic [A_W-1:0]         a;

    // The pipeline moves whenever the output register can take a beat.
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Radius register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_sphere_radius;
        end
    end

    gcd_front #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
        .ZW                  (ZW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .lat1      (s_first_latitude),
        .lon1      (s_first_longitude),
        .lat2      (s_second_latitude),
        .lon2      (s_second_longitude),
        .out_valid (f_valid),
        .angle     (angle)
    );

    gcd_sincos #(
        .ZW           (ZW),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .angle     (angle),
        .out_valid (c_valid),
        .cp1       (cp1),
        .cp2       (cp2),
        .s1        (s1),
        .s2        (s2)
    );

    gcd_hav u_hav (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid),
        .cp1       (cp1),
        .cp2       (cp2),
        .s1        (s1),
        .s2        (s2),
        .out_valid (h_valid),
        .a         (a)
    );

    gcd_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (h_valid),
        .a         (a),
        .out_valid (q_valid),
        .ys        (ys),
        .xs        (xs)
    );

    gcd_vector #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_vector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .ys        (ys),
        .xs        (xs),
        .radius    (radius_reg),
        .out_valid (m_valid),
        .distance  (m_distance)
    );

endmodule

@@ verif/great_circle_distance_tb.sv @@
// Self-checking testbench for the great_circle_distance pipeline.
// It depends on gcd_pkg and the RTL top, and holds its own haversine predictor.
`timescale 1ns / 100ps

module great_circle_distance_tb;
    import gcd_pkg::*;

    localparam int  STEPS        = 32;
    localparam int  FRAC         = 23;
    localparam int  PIPE_LATENCY = 2 * STEPS + 48;
    localparam int  DRAIN_WAIT   = PIPE_LATENCY + 40;
    localparam int  WATCHDOG_MAX = 4000;
    localparam int  LAT_LIMIT    = 754974720;
    localparam int  LON_LIMIT    = 1509949440;
    localparam int  RADIUS_MAX   = 524288000;
    localparam logic [63:0] PI_FIX     = 64'h3243F6A8885A308D;
    localparam longint      PI_RAD     = longint'((PI_FIX + 64'd524288) >> 20);
    localparam longint      HALF_PI    = longint'((PI_FIX + 64'd1048576) >> 21);
    localparam logic [63:0] DEG_TO_RAD = (PI_FIX + (64'd90 << 24)) / (64'd180 << 24);
    localparam longint      UNIT_A     = 64'sd1 << 60;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [LAT_W-1:0] s_first_latitude;
    logic signed [LON_W-1:0] s_first_longitude;
    logic signed [LAT_W-1:0] s_second_latitude;
    logic signed [LON_W-1:0] s_second_longitude;
    logic                    m_valid;
    logic                    m_ready;
    logic [DIST_W-1:0]       m_distance;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [RADIUS_W-1:0]     cfg_sphere_radius;

    // Predictor state: angle table, gain correction and the radius register.
    longint              arc_table [STEPS];
    longint              gain_init;
    logic [RADIUS_W-1:0] radius_now;

    logic [DIST_W-1:0] expected_distances [$];
    int                mismatch_count;
    int                idle_cycles;
    int                stall_mode;
    int                stall_count;

    great_circle_distance u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_latitude   (s_first_latitude),
        .s_first_longitude  (s_first_longitude),
        .s_second_latitude  (s_second_latitude),
        .s_second_longitude (s_second_longitude),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_distance         (m_distance),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_sphere_radius  (cfg_sphere_radius)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Circular rotation; x and y are updated in place, z steers each micro-rotation.
    task automatic rotate_vec(inout longint x, inout longint y, input longint z);
        longint dx;
        longint dy;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - arc_table[i];
            end else begin
                x = x + dx; y = y - dy; z = z + arc_table[i];
            end
        end
    endtask

    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + arc_table[i];
            end else begin
                x = x - dx; y = y + dy; z = z - arc_table[i];
            end
        end
        return z;
    endfunction

    task automatic build_tables();
        longint      sum;
        longint      p;
        logic [63:0] term;
        longint      gx;
        longint      gy;
        arc_table[0] = longint'((PI_FIX + 64'd2097152) >> 22);
        for (int i = 1; i < STEPS; i++) begin
            sum = 0;
            for (int k = 0; k < 64; k++) begin
                p = longint'(i) * (2 * k + 1);
                if (p <= 62) begin
                    term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
                    if (k % 2 == 1) sum = sum - longint'(term);
                    else sum = sum + longint'(term);
                end
            end
            arc_table[i] = (sum + 64'sd2097152) >>> 22;
        end
        gx = 64'sd1 << 30;
        gy = 0;
        rotate_vec(gx, gy, 0);
        if (gx <= 0) gx = 1;
        gain_init = longint'(((64'd1 << 60) + (64'(gx) >> 1)) / 64'(gx));
    endtask

    // Degrees in 2^-23 units to Q40 radians; extra adds one shift for half angles.
    function automatic longint deg_to_rad(input longint deg, input int extra);
        logic [63:0] mag;
        logic [63:0] r;
        int          sh;
        mag = deg < 0 ? 64'(-deg) : 64'(deg);
        sh  = FRAC - 4 + extra;
        r   = (mag * DEG_TO_RAD + (64'd1 << (sh - 1))) >> sh;
        return deg < 0 ? -longint'(r) : longint'(r);
    endfunction

    task automatic sine_cosine(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        bit     flip;
        x = gain_init;
        y = 0;
        flip = 1'b0;
        if (ang > HALF_PI) begin
            ang = ang - PI_RAD; flip = 1'b1;
        end else if (ang < -HALF_PI) begin
            ang = ang + PI_RAD; flip = 1'b1;
        end
        rotate_vec(x, y, ang);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint isqrt_round(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (v > r) r = r + 1;
        return longint'(r);
    endfunction

    task automatic predict_distance(input longint lat1, input longint lon1,
                                    input longint lat2, input longint lon2,
                                    output logic [DIST_W-1:0] dist_val);
        longint      half_turn;
        longint      full_turn;
        longint      dlon;
        longint      sp1, cp1, sp2, cp2, s1, c1, s2, c2;
        longint      hav;
        longint      ys;
        longint      xs;
        longint      z;
        longint      theta;
        logic [63:0] prod;
        half_turn = 64'sd180 << FRAC;
        full_turn = 64'sd360 << FRAC;
        dlon = (lon2 - lon1 + half_turn) % full_turn;
        if (dlon < 0) dlon = dlon + full_turn;
        dlon = dlon - half_turn;
        sine_cosine(deg_to_rad(lat1, 0), sp1, cp1);
        sine_cosine(deg_to_rad(lat2, 0), sp2, cp2);
        sine_cosine(deg_to_rad(lat2 - lat1, 1), s1, c1);
        sine_cosine(deg_to_rad(dlon, 1), s2, c2);
        hav = s1 * s1 + ((cp1 * cp2 + (64'sd1 << 29)) >>> 30)
                      * ((s2 * s2 + (64'sd1 << 29)) >>> 30);
        if (hav < 0) hav = 0;
        if (hav > UNIT_A) hav = UNIT_A;
        ys = isqrt_round(64'(hav));
        xs = isqrt_round(64'(UNIT_A - hav));
        z = vector_angle(xs, ys);
        if (z < 0) z = 0;
        theta = (z + 64) >>> 7;
        prod = (64'(radius_now) * 64'(theta) + (64'd1 << 31)) >> 32;
        dist_val = prod[DIST_W-1:0];
    endtask

    // Present one point pair and hold it until accepted; valid stays high afterwards.
    task automatic send_pair(input longint lat1, input longint lon1,
                             input longint lat2, input longint lon2);
        logic [DIST_W-1:0] dist_val;
        bit                taken;
        s_valid            <= 1'b1;
        s_first_latitude   <= LAT_W'(lat1);
        s_first_longitude  <= LON_W'(lon1);
        s_second_latitude  <= LAT_W'(lat2);
        s_second_longitude <= LON_W'(lon2);
        // Predict from the values as the port sees them.
        predict_distance(longint'($signed(LAT_W'(lat1))), longint'($signed(LON_W'(lon1))),
                         longint'($signed(LAT_W'(lat2))), longint'($signed(LON_W'(lon2))),
                         dist_val);
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        expected_distances.push_back(dist_val);
    endtask

    task automatic sender_gap(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Radius writes happen only once the pipeline has drained.
    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        bit taken;
        sender_gap(1);
        while (expected_distances.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_valid         <= 1'b1;
        cfg_sphere_radius <= value;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid  <= 1'b0;
        radius_now = value;
    endtask

    function automatic longint rand_lat();
        return longint'($urandom_range(2 * LAT_LIMIT, 0)) - LAT_LIMIT;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(32'(2 * 64'(LON_LIMIT)), 0)) - LON_LIMIT;
    endfunction

    // Random point pair; a few use the full port width, some share a point.
    task automatic send_random_pair();
        longint lat1, lon1, lat2, lon2;
        int     pick;
        pick = $urandom_range(99, 0);
        lat1 = rand_lat();
        lon1 = rand_lon();
        lat2 = rand_lat();
        lon2 = rand_lon();
        if (pick < 8) begin
            lat1 = longint'($signed(LAT_W'($urandom)));
            lon1 = longint'($signed(LON_W'($urandom)));
            lat2 = longint'($signed(LAT_W'($urandom)));
            lon2 = longint'($signed(LON_W'($urandom)));
        end else if (pick < 14) begin
            lat2 = lat1;
            lon2 = lon1;
        end else if (pick < 30) begin
            // Nearby points exercise the small-angle end of the roots.
            lat2 = lat1 + longint'($urandom_range(2000, 0)) - 1000;
            lon2 = lon1 + longint'($urandom_range(2000, 0)) - 1000;
        end
        send_pair(lat1, lon1, lat2, lon2);
    endtask

    // Bursts of random length separated by random gaps.
    task automatic send_random_bursts(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(40, 1);
            if (burst > left) burst = left;
            repeat (burst) send_random_pair();
            left = left - burst;
            if ($urandom_range(3, 0) != 0) sender_gap($urandom_range(12, 1));
        end
    endtask

    task automatic test_directed_extremes();
        longint deg;
        deg = 64'sd1 << FRAC;
        send_pair(0, 0, 0, 0);
        send_pair(LAT_LIMIT, 0, -LAT_LIMIT, 0);
        send_pair(-LAT_LIMIT, -LON_LIMIT, LAT_LIMIT, LON_LIMIT);
        send_pair(0, -LON_LIMIT, 0, LON_LIMIT);
        send_pair(0, 0, 0, 180 * deg);
        send_pair(0, 0, 0, -180 * deg);
        send_pair(0, 179 * deg, 0, -179 * deg);
        send_pair(10 * deg, 100 * deg, 10 * deg, 100 * deg);
        send_pair(LAT_LIMIT, LON_LIMIT, LAT_LIMIT, -LON_LIMIT);
        sender_gap(3);
        // Latitudes past the poles and the full signed range of every port.
        send_pair(100 * deg, 0, -100 * deg, 30 * deg);
        send_pair(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
        send_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
        send_pair(-1, -1, -1, -1);
        send_pair(1, 0, 0, 1);
        send_pair(45 * deg, 0, 45 * deg, 90 * deg);
        send_pair(0, 0, 90 * deg, 0);
        sender_gap(2);
    endtask

    task automatic test_radius_extremes();
        logic [RADIUS_W-1:0] settings [5];
        settings[0] = 29'd1;
        settings[1] = 29'(RADIUS_MAX);
        settings[2] = '1;
        settings[3] = '0;
        settings[4] = 29'd12345678;
        foreach (settings[i]) begin
            write_radius(settings[i]);
            send_pair(-LAT_LIMIT, 0, LAT_LIMIT, 0);
            send_pair(0, 0, 0, 180 << FRAC);
            send_random_bursts(40);
        end
    endtask

    task automatic test_random_pairs();
        write_radius(RADIUS_RESET);
        send_random_bursts(700);
        write_radius(29'($urandom_range(RADIUS_MAX, 1)));
        send_random_bursts(500);
    endtask

    // Receiver: always ready, random stalls, or long stalls, switched now and then.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_mode  <= 0;
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count % 300 == 299) stall_mode <= $urandom_range(2, 0);
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(2, 0) != 0);
                end
                default: begin
                    m_ready <= (stall_count % 16 < 5);
                end
            endcase
        end
    end

    // Compare each result beat with the oldest prediction; also the watchdog.
    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_distances.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected distance beat: actual %0d", m_distance);
                end else begin
                    if (m_distance !== expected_distances[0]) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("distance mismatch: expected %0d actual %0d",
                                     expected_distances[0], m_distance);
                    end
                    void'(expected_distances.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("great_circle_distance regression: fail");
                $finish;
            end
        end
    end

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_first_latitude   = '0;
        s_first_longitude  = '0;
        s_second_latitude  = '0;
        s_second_longitude = '0;
        cfg_valid          = 1'b0;
        cfg_sphere_radius  = '0;
        mismatch_count     = 0;
        idle_cycles        = 0;
        radius_now         = RADIUS_RESET;
        build_tables();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_radius_extremes();
        test_random_pairs();

        sender_gap(1);
        while (expected_distances.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("great_circle_distance regression: pass");
        end else begin
            $display("great_circle_distance regression: fail");
        end
        $finish;
    end

endmodule
